// ----- hw/rtl/dq_pkg.sv -----
// Shared types, sizes and codes for the double-ended queue.
// Depends on nothing; imported by every module of the block but dq_ram.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int ITEM_W     = 32;
  localparam int ACTION_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int FAULT_W    = 2;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [IDX_W:0]        idx_sum_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ITEM_W-1:0]     item_t;
  typedef logic [COUNT_W-1:0]    count_out_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_RIGHT = 2'd0,
    ACT_POP_LEFT   = 2'd1,
    ACT_POP_RIGHT  = 2'd2,
    ACT_NOP        = 2'd3
  } action_e;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_OK    = 2'd0,
    FAULT_EMPTY = 2'd1,
    FAULT_FULL  = 2'd2
  } fault_e;

  // Result item, first field in the highest bits.
  typedef struct packed {
    fault_e     fault;
    logic       is_full;
    logic       is_empty;
    count_out_t entry_count;
    item_t      right_value;
    item_t      left_value;
    logic       popped_valid;
    item_t      popped_value;
  } result_t;

  localparam int RES_W     = $bits(result_t);
  localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int S_TDATA_W = ITEM_W;
  localparam int S_TUSER_W = ((ACTION_W + 7) / 8) * 8;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic load_now;
    logic load_read;
  } dq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pop_ok;
  } dq_stat_t;

  // Ring slot at offset off from base; off is at most DEPTH.
  function automatic idx_t slot_at(idx_t base, cnt_t off);
    idx_sum_t s;
    s = idx_sum_t'(base) + idx_sum_t'(off);
    if (s >= idx_sum_t'(DEPTH)) begin
      s = s - idx_sum_t'(DEPTH);
    end
    return idx_t'(s);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dq_ctrl.sv -----
// Controller of the double-ended queue: handshakes and sequencing of pops.
// Depends on dq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  output logic                   s_ready_o,
  output logic                   m_valid_o,
  input  wire logic              m_ready_i,
  input  wire dq_pkg::dq_stat_t  stat_i,
  output dq_pkg::dq_cmd_t        cmd_o
);
  import dq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    state_d         = state_q;
    s_ready_o       = 1'b0;
    accept          = 1'b0;
    cmd_o.load_now  = 1'b0;
    cmd_o.load_read = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = out_free;
        accept    = s_valid_i && out_free;
        if (accept) begin
          if (stat_i.pop_ok) begin
            state_d = ST_READ;
          end else begin
            cmd_o.load_now = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          cmd_o.load_read = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    cmd_o.accept = accept;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_now || cmd_o.load_read) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dq_datapath.sv -----
// Datapath of the double-ended queue: ring pointer, count, peek registers,
// slot RAM and result register. Depends on dq_pkg and dq_ram.
`timescale 1ns / 1ps
`default_nettype none

module dq_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dq_pkg::action_e   action_i,
  input  wire dq_pkg::item_t     item_value_i,
  input  wire dq_pkg::dq_cmd_t   cmd_i,
  output dq_pkg::dq_stat_t       stat_o,
  output dq_pkg::result_t        result_o
);
  import dq_pkg::*;

  idx_t    left_idx_q, left_idx_d;
  cnt_t    count_q, count_d;
  data_t   left_val_q, left_val_d;
  data_t   right_val_q, right_val_d;
  data_t   popped_q, popped_d;
  logic    side_left_q, side_left_d;
  result_t res_q, res_d;

  logic    is_push, pop_l, pop_r, empty, full, push_ok, pop_ok;
  data_t   value;
  data_t   rdata;
  idx_t    waddr, raddr, left_next;
  cnt_t    right_off;
  fault_e  fault_now;

  cnt_t    r_cnt;
  data_t   r_left, r_right, r_popped;
  logic    r_pvalid;
  fault_e  r_fault;

  assign value   = data_t'(item_value_i);
  assign is_push = (action_i == ACT_PUSH_RIGHT);
  assign pop_l   = (action_i == ACT_POP_LEFT);
  assign pop_r   = (action_i == ACT_POP_RIGHT);
  assign empty   = (count_q == '0);
  assign full    = (count_q == cnt_t'(DEPTH));
  assign push_ok = is_push && !full;
  assign pop_ok  = (pop_l || pop_r) && !empty;

  assign stat_o.pop_ok = pop_ok;

  always_comb begin
    if ((pop_l || pop_r) && empty) begin
      fault_now = FAULT_EMPTY;
    end else if (is_push && full) begin
      fault_now = FAULT_FULL;
    end else begin
      fault_now = FAULT_OK;
    end
  end

  assign left_next = slot_at(left_idx_q, cnt_t'(1));
  assign right_off = (count_q >= cnt_t'(2)) ? count_q - cnt_t'(2) : '0;
  assign waddr     = slot_at(left_idx_q, count_q);
  assign raddr     = pop_l ? left_next : slot_at(left_idx_q, right_off);

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && push_ok),
    .waddr_i (waddr),
    .wdata_i (value),
    .re_i    (cmd_i.accept && pop_ok),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    left_idx_d  = left_idx_q;
    count_d     = count_q;
    left_val_d  = left_val_q;
    right_val_d = right_val_q;
    popped_d    = popped_q;
    side_left_d = side_left_q;
    if (cmd_i.accept) begin
      if (push_ok) begin
        count_d     = count_q + cnt_t'(1);
        right_val_d = value;
        if (empty) begin
          left_val_d = value;
        end
      end
      if (pop_ok) begin
        count_d     = count_q - cnt_t'(1);
        popped_d    = pop_l ? left_val_q : right_val_q;
        side_left_d = pop_l;
        if (pop_l) begin
          left_idx_d = left_next;
        end
      end
    end
    if (cmd_i.load_read) begin
      if (side_left_q) begin
        left_val_d = rdata;
      end else begin
        right_val_d = rdata;
      end
    end
  end

  always_comb begin
    if (cmd_i.load_read) begin
      r_cnt    = count_q;
      r_popped = popped_q;
      r_pvalid = 1'b1;
      r_fault  = FAULT_OK;
    end else begin
      r_cnt    = count_d;
      r_popped = '0;
      r_pvalid = 1'b0;
      r_fault  = fault_now;
    end
    r_left  = (r_cnt == '0) ? '0 : left_val_d;
    r_right = (r_cnt == '0) ? '0 : right_val_d;

    res_d.popped_value = item_t'(r_popped);
    res_d.popped_valid = r_pvalid;
    res_d.left_value   = item_t'(r_left);
    res_d.right_value  = item_t'(r_right);
    res_d.entry_count  = count_out_t'(r_cnt);
    res_d.is_empty     = (r_cnt == '0);
    res_d.is_full      = (r_cnt == cnt_t'(DEPTH));
    res_d.fault        = r_fault;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_idx_q <= '0;
      count_q    <= '0;
    end else begin
      left_idx_q <= left_idx_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_val_q  <= left_val_d;
    right_val_q <= right_val_d;
    popped_q    <= popped_d;
    side_left_q <= side_left_d;
    if (cmd_i.load_now || cmd_i.load_read) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/double_ended_queue.sv -----
// Bounded double-ended queue of DEPTH entries held in a ring buffer.
// A push, a failed pop or a no-operation transaction delivers its result in the
// register after the accepting edge, so these run at one per cycle while the
// output is drained. A successful pop goes through a read state that takes in
// no new transaction: the new leftmost or rightmost entry comes from the slot
// RAM, whose read data is registered. The next transaction is taken in the
// cycle that a waiting result is accepted; while a result stalls, the input is
// held off. Every result carries the popped value, both peeks, the count, the
// flags and a fault code; a pop on empty and a push on full change nothing.
// Depends on dq_pkg, dq_ctrl, dq_datapath and dq_ram.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // item_value[31:0]
  input  wire logic [dq_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // action[1:0], zero above
  input  wire logic [dq_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // popped_value[31:0], popped_valid[32], left_value[64:33],
  // right_value[96:65], entry_count[101:97], is_empty[102], is_full[103],
  // fault[105:104], zero above
  output logic      [dq_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
  import dq_pkg::*;

  dq_cmd_t  cmd;
  dq_stat_t stat;
  result_t  result;

  dq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  dq_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (action_e'(s_axis_tuser[ACTION_W-1:0])),
    .item_value_i (item_t'(s_axis_tdata)),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .result_o     (result)
  );

  assign m_axis_tdata = M_TDATA_W'(result);

endmodule

`default_nettype wire

// ----- hw/rtl/dq_checker.sv -----
// Port-level assertions for the double-ended queue, bound to the top level.
// Depends on dq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dq_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic [dq_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input wire logic [dq_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [dq_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import dq_pkg::*;

  result_t res;
  assign res = result_t'(m_axis_tdata[RES_W-1:0]);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.entry_count <= count_out_t'(DEPTH))
    else $error("entry count beyond depth");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.is_empty == (res.entry_count == '0)) &&
                      (res.is_full == (res.entry_count == count_out_t'(DEPTH))))
    else $error("empty or full flag disagrees with count");

  a_fault_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.fault != FAULT_OK |->
      !res.popped_valid && res.popped_value == '0)
    else $error("faulted transaction reports a pop");

  a_empty_peek: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.is_empty |->
      res.left_value == '0 && res.right_value == '0)
    else $error("empty queue shows a peek value");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

`default_nettype wire

// ----- sim/tb_double_ended_queue.sv -----
// Self-checking testbench for double_ended_queue: directed edge cases, then
// random push/pop traffic under several sender/receiver stall mixes.
// Depends on dq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps

module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTED = 10;
  localparam int PHASE_ITEMS  = 175;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Predicted deque contents.
  item_t ring_q [DEPTH];
  int    head_idx = 0;
  int    held_n = 0;

  result_t expected_q[$];
  int      sender_idle_pct = 0;
  int      sink_stall_pct = 0;
  int      fail_count = 0;
  int      cycle_cnt = 0;

  double_ended_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic int ring_pos(int offset);
    return (head_idx + offset) % DEPTH;
  endfunction

  // Apply one operation to the predicted deque and return its result.
  function automatic result_t deque_step(action_e act, item_t val);
    result_t r;
    r = '0;
    r.fault = FAULT_OK;
    case (act)
      ACT_PUSH_RIGHT: begin
        if (held_n >= DEPTH) begin
          r.fault = FAULT_FULL;
        end else begin
          ring_q[ring_pos(held_n)] = val;
          held_n++;
        end
      end
      ACT_POP_LEFT: begin
        if (held_n == 0) begin
          r.fault = FAULT_EMPTY;
        end else begin
          r.popped_value = ring_q[head_idx];
          r.popped_valid = 1'b1;
          head_idx = (head_idx + 1) % DEPTH;
          held_n--;
        end
      end
      ACT_POP_RIGHT: begin
        if (held_n == 0) begin
          r.fault = FAULT_EMPTY;
        end else begin
          r.popped_value = ring_q[ring_pos(held_n - 1)];
          r.popped_valid = 1'b1;
          held_n--;
        end
      end
      default: begin
      end
    endcase
    if (held_n != 0) begin
      r.left_value  = ring_q[ring_pos(0)];
      r.right_value = ring_q[ring_pos(held_n - 1)];
    end
    r.entry_count = count_out_t'(held_n);
    r.is_empty    = (held_n == 0);
    r.is_full     = (held_n >= DEPTH);
    return r;
  endfunction

  // Check each delivered result against the oldest prediction.
  always @(posedge clk_i) begin
    result_t got;
    result_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[RES_W-1:0]);
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTED) begin
          $display("unexpected result: pop %h/%b l %h r %h n %0d e %b f %b fault %0d",
                   got.popped_value, got.popped_valid, got.left_value,
                   got.right_value, got.entry_count, got.is_empty, got.is_full,
                   got.fault);
        end
      end else begin
        exp = expected_q.pop_front();
        if (got.popped_value !== exp.popped_value ||
            got.popped_valid !== exp.popped_valid ||
            got.left_value !== exp.left_value ||
            got.right_value !== exp.right_value ||
            got.entry_count !== exp.entry_count ||
            got.is_empty !== exp.is_empty ||
            got.is_full !== exp.is_full ||
            got.fault !== exp.fault) begin
          fail_count++;
          if (fail_count <= MAX_REPORTED) begin
            $display("mismatch exp: pop %h/%b l %h r %h n %0d e %b f %b fault %0d",
                     exp.popped_value, exp.popped_valid, exp.left_value,
                     exp.right_value, exp.entry_count, exp.is_empty, exp.is_full,
                     exp.fault);
            $display("         got: pop %h/%b l %h r %h n %0d e %b f %b fault %0d",
                     got.popped_value, got.popped_valid, got.left_value,
                     got.right_value, got.entry_count, got.is_empty, got.is_full,
                     got.fault);
          end
        end
      end
    end
  end

  // Called and returns at a falling edge; tvalid stays high after acceptance.
  task automatic send_op(input action_e act, input item_t val);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= S_TUSER_W'(act);
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.insert(expected_q.size(), deque_step(act, val));
    @(negedge clk_i);
  endtask

  task automatic test_empty_faults();
    send_op(ACT_POP_LEFT, 32'hFFFF_FFFF);
    send_op(ACT_POP_RIGHT, 32'h1234_5678);
    send_op(ACT_NOP, 32'hFFFF_FFFF);
  endtask

  task automatic test_end_values();
    send_op(ACT_PUSH_RIGHT, 32'hFFFF_FFFF);
    send_op(ACT_PUSH_RIGHT, 32'h0000_0000);
    send_op(ACT_NOP, 32'hDEAD_BEEF);
    send_op(ACT_POP_RIGHT, 32'h0);
    send_op(ACT_POP_LEFT, 32'h0);
  endtask

  task automatic test_fill_and_overflow();
    for (int i = 0; i < DEPTH; i++) begin
      send_op(ACT_PUSH_RIGHT, ((i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA) ^ item_t'(i));
    end
    send_op(ACT_PUSH_RIGHT, 32'hCAFE_F00D);
    send_op(ACT_POP_LEFT, 32'h0);
    send_op(ACT_POP_RIGHT, 32'h0);
  endtask

  // Alternate fill-heavy and drain-heavy runs so both ends get hit often.
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    bit      filling;
    int      sel;
    action_e act;
    item_t   val;
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    filling = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (held_n == DEPTH && $urandom_range(3) == 0) begin
        filling = 1'b0;
      end else if (held_n == 0 && $urandom_range(3) == 0) begin
        filling = 1'b1;
      end else if ($urandom_range(39) == 0) begin
        filling = !filling;
      end
      sel = $urandom_range(99);
      if (sel < 8) begin
        act = ACT_NOP;
      end else if (sel < (filling ? 70 : 30)) begin
        act = ACT_PUSH_RIGHT;
      end else if ($urandom_range(1) == 0) begin
        act = ACT_POP_LEFT;
      end else begin
        act = ACT_POP_RIGHT;
      end
      case ($urandom_range(7))
        0: val = '0;
        1: val = '1;
        default: val = $urandom;
      endcase
      send_op(act, val);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_empty_faults();
    test_end_values();
    test_fill_and_overflow();
    test_random_traffic(PHASE_ITEMS, 0, 0);
    test_random_traffic(PHASE_ITEMS, 88, 0);
    test_random_traffic(PHASE_ITEMS, 0, 88);
    test_random_traffic(PHASE_ITEMS, 24, 24);

    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
